// ----- rtl/tssd_pkg.sv -----
package tssd_pkg;

    // Table geometry
    localparam int STOP_TOKENS = 16;
    localparam int NUM_SEQS    = 8;
    localparam int MAX_SEQ_LEN = 8;
    localparam int TOKEN_BITS  = 20;

    // Field widths
    localparam int CMD_BITS      = 2;
    localparam int SLOT_BITS     = 4;
    localparam int POS_BITS      = 3;
    localparam int REASON_BITS   = 2;
    localparam int COUNT_BITS    = 16;
    localparam int EOS_BITS      = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    // Derived widths
    localparam int STOP_AW  = $clog2(STOP_TOKENS);
    localparam int SEQ_AW   = $clog2(NUM_SEQS);
    localparam int HIST_AW  = $clog2(MAX_SEQ_LEN);
    localparam int LEN_W    = $clog2(MAX_SEQ_LEN + 1);
    localparam int WALK_LEN = (STOP_TOKENS > NUM_SEQS) ? STOP_TOKENS : NUM_SEQS;
    localparam int WALK_W   = $clog2(WALK_LEN);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TOKEN    = 2'd0,
        CMD_START    = 2'd1,
        CMD_STOP_TOK = 2'd2,
        CMD_STOP_SEQ = 2'd3
    } cmd_t;

    typedef enum logic [REASON_BITS-1:0] {
        FIN_NONE   = 2'd0,
        FIN_STOP   = 2'd1,
        FIN_LENGTH = 2'd2
    } reason_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IGNORE_EOS    = 3'd0,
        CFG_EOS_TOKEN     = 3'd1,
        CFG_MAX_GENERATED = 3'd2,
        CFG_MAX_TOTAL     = 3'd3,
        CFG_PROMPT_LENGTH = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_DONE
    } state_t;

    // Table write request toward the match unit
    typedef struct packed {
        logic                  stop_we;
        logic                  seq_we;
        logic [SLOT_BITS-1:0]  slot;
        logic [POS_BITS-1:0]   pos;
        logic                  flag;
        logic [TOKEN_BITS-1:0] token;
    } tbl_wr_t;

    // Table walk read control
    typedef struct packed {
        logic              rd_en;
        logic [WALK_W-1:0] rd_idx;
    } walk_t;

endpackage

// ----- rtl/tssd_match.sv -----
module tssd_match (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  tssd_pkg::tbl_wr_t                                       tbl_wr,
    input  tssd_pkg::walk_t                                         walk,
    input  logic [tssd_pkg::MAX_SEQ_LEN-1:0][tssd_pkg::TOKEN_BITS-1:0] history,
    input  logic [tssd_pkg::LEN_W-1:0]                              fill,
    output logic                                                    cmp_hit
);
    import tssd_pkg::*;

    logic [TOKEN_BITS-1:0]                  stop_mem [STOP_TOKENS];
    logic [MAX_SEQ_LEN-1:0][TOKEN_BITS-1:0] seq_mem  [NUM_SEQS];
    logic                                   stop_valid_reg [STOP_TOKENS];
    logic [LEN_W-1:0]                       seq_len_reg    [NUM_SEQS];

    logic                                   rd_stop_en_reg;
    logic                                   rd_seq_en_reg;
    logic [TOKEN_BITS-1:0]                  stop_rd_reg;
    logic                                   stop_vld_rd_reg;
    logic [MAX_SEQ_LEN-1:0][TOKEN_BITS-1:0] seq_rd_reg;
    logic [LEN_W-1:0]                       len_rd_reg;

    logic             stop_wr_ok;
    logic             seq_wr_ok;
    logic             rd_stop_ok;
    logic             rd_seq_ok;
    logic             lanes_ok;
    logic [LEN_W-1:0] hidx;
    logic             stop_hit;
    logic             seq_hit;

    assign stop_wr_ok = tbl_wr.stop_we && (int'(tbl_wr.slot) < STOP_TOKENS);
    assign seq_wr_ok  = tbl_wr.seq_we && (int'(tbl_wr.slot) < NUM_SEQS)
                        && (int'(tbl_wr.pos) < MAX_SEQ_LEN);
    assign rd_stop_ok = walk.rd_en && (int'(walk.rd_idx) < STOP_TOKENS);
    assign rd_seq_ok  = walk.rd_en && (int'(walk.rd_idx) < NUM_SEQS);

    // Token memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (stop_wr_ok) begin
            stop_mem[tbl_wr.slot[STOP_AW-1:0]] <= tbl_wr.token;
        end
        if (seq_wr_ok) begin
            seq_mem[tbl_wr.slot[SEQ_AW-1:0]][tbl_wr.pos[HIST_AW-1:0]] <= tbl_wr.token;
        end
        stop_rd_reg     <= stop_mem[walk.rd_idx[STOP_AW-1:0]];
        stop_vld_rd_reg <= stop_valid_reg[walk.rd_idx[STOP_AW-1:0]];
        seq_rd_reg      <= seq_mem[walk.rd_idx[SEQ_AW-1:0]];
        len_rd_reg      <= seq_len_reg[walk.rd_idx[SEQ_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STOP_TOKENS; i++) begin
                stop_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_SEQS; i++) begin
                seq_len_reg[i] <= '0;
            end
            rd_stop_en_reg <= 1'b0;
            rd_seq_en_reg  <= 1'b0;
        end else begin
            if (stop_wr_ok) begin
                stop_valid_reg[tbl_wr.slot[STOP_AW-1:0]] <= tbl_wr.flag;
            end
            if (seq_wr_ok && tbl_wr.flag) begin
                seq_len_reg[tbl_wr.slot[SEQ_AW-1:0]] <= LEN_W'(tbl_wr.pos) + LEN_W'(1);
            end
            rd_stop_en_reg <= rd_stop_ok;
            rd_seq_en_reg  <= rd_seq_ok;
        end
    end

    // Sequence position p must equal history entry len-1-p
    always_comb begin
        lanes_ok = 1'b1;
        hidx     = '0;
        for (int p = 0; p < MAX_SEQ_LEN; p++) begin
            hidx = len_rd_reg - LEN_W'(1) - LEN_W'(p);
            if ((LEN_W'(p) < len_rd_reg) && (seq_rd_reg[p] != history[hidx[HIST_AW-1:0]])) begin
                lanes_ok = 1'b0;
            end
        end
    end

    assign seq_hit  = rd_seq_en_reg && (len_rd_reg != '0) && (len_rd_reg <= fill) && lanes_ok;
    assign stop_hit = rd_stop_en_reg && stop_vld_rd_reg && (stop_rd_reg == history[0]);
    assign cmp_hit  = stop_hit | seq_hit;

endmodule

// ----- rtl/token_stream_stop_detector.sv -----
// Token stream stop detector. Each request on the s_ channel carries a command: a token
// (s_cmd token) is appended to an 8-deep history and checked against the end-of-sequence
// token, the 16-entry stop-token table and the 8 stop sequences (matched as a suffix of the
// history), then against the total and generated length limits; it returns one result with
// the finish reason and the saturating token count. Start-request and table-load commands
// return nothing. A token is accepted, then the walk reads the stop-token table memory a
// word a cycle, one step per entry (the stop-sequence memory is read a whole sequence per
// word alongside it), the last read is compared in ST_LAST and the result is loaded into
// the output register once that register is free. The output register holds a result
// until taken while the next request is accepted. There is no clearing pass after reset.
// Configuration writes are accepted at any time (cfg_ready is tied high) and must only be
// issued while no token is in flight.
module token_stream_stop_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tssd_pkg::CMD_BITS-1:0]       s_cmd,
    input  logic [tssd_pkg::TOKEN_BITS-1:0]     s_token,
    input  logic [tssd_pkg::SLOT_BITS-1:0]      s_slot,
    input  logic [tssd_pkg::POS_BITS-1:0]       s_position,
    input  logic                                s_flag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tssd_pkg::REASON_BITS-1:0]    m_finish_reason,
    output logic [tssd_pkg::COUNT_BITS-1:0]     m_tokens_seen,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tssd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tssd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tssd_pkg::*;

    state_t state_reg, state_next;

    // Configuration registers
    logic                  ignore_eos_reg;
    logic [EOS_BITS-1:0]   eos_reg;
    logic [COUNT_BITS-1:0] max_gen_reg;
    logic [COUNT_BITS-1:0] max_total_reg;
    logic [COUNT_BITS-1:0] prompt_reg;

    // Request state
    logic [MAX_SEQ_LEN-1:0][TOKEN_BITS-1:0] history_reg;
    logic [LEN_W-1:0]                       fill_reg;
    logic [COUNT_BITS-1:0]                  count_reg;
    logic [WALK_W-1:0]                      idx_reg;
    logic                                   hit_reg;

    // Output register
    logic                   m_valid_reg;
    reason_t                m_reason_reg;
    logic [COUNT_BITS-1:0]  m_count_reg;

    logic                  s_fire;
    cmd_t                  cmd;
    logic                  deliver;
    logic                  cmp_hit;
    logic                  limit_hit;
    logic [COUNT_BITS-1:0] gen_count;
    reason_t               reason_next;
    tbl_wr_t               tbl_wr;
    walk_t                 walk;

    assign cmd       = cmd_t'(s_cmd);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (cmd == CMD_TOKEN)) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (idx_reg == WALK_W'(WALK_LEN - 1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: state_next = ST_DONE;
            ST_DONE: begin
                if (deliver) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs: input handshake, table walk, table writes, result delivery
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        walk.rd_en     = (state_reg == ST_WALK);
        walk.rd_idx    = idx_reg;
        deliver        = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        tbl_wr.stop_we = s_fire && (cmd == CMD_STOP_TOK);
        tbl_wr.seq_we  = s_fire && (cmd == CMD_STOP_SEQ);
        tbl_wr.slot    = s_slot;
        tbl_wr.pos     = s_position;
        tbl_wr.flag    = s_flag;
        tbl_wr.token   = s_token;
    end

    // Length limits against the saturated count; prompt tokens count as zero generated
    always_comb begin
        gen_count = (count_reg > prompt_reg) ? (count_reg - prompt_reg) : '0;
        limit_hit = ((max_total_reg != '0) && (count_reg >= max_total_reg))
                    || ((max_gen_reg != '0) && (gen_count >= max_gen_reg));
        priority if (hit_reg) begin
            reason_next = FIN_STOP;
        end else if (limit_hit) begin
            reason_next = FIN_LENGTH;
        end else begin
            reason_next = FIN_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_eos_reg <= 1'b0;
            eos_reg        <= '0;
            max_gen_reg    <= '0;
            max_total_reg  <= '0;
            prompt_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IGNORE_EOS:    ignore_eos_reg <= cfg_data[0];
                CFG_EOS_TOKEN:     eos_reg        <= cfg_data[EOS_BITS-1:0];
                CFG_MAX_GENERATED: max_gen_reg    <= cfg_data[COUNT_BITS-1:0];
                CFG_MAX_TOTAL:     max_total_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_PROMPT_LENGTH: prompt_reg     <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // History taps only matter below the fill level, so they need no clear
    always_ff @(posedge aclk) begin
        if (s_fire && (cmd == CMD_TOKEN)) begin
            history_reg <= {history_reg[MAX_SEQ_LEN-2:0], s_token};
        end
    end

    // Fill, count, walk index and the sticky stop hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (s_fire && (cmd == CMD_START)) begin
                fill_reg  <= '0;
                count_reg <= '0;
            end else if (s_fire && (cmd == CMD_TOKEN)) begin
                if (fill_reg != LEN_W'(MAX_SEQ_LEN)) begin
                    fill_reg <= fill_reg + LEN_W'(1);
                end
                if (count_reg != '1) begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
                // seed the hit with the end-of-sequence check
                hit_reg <= !ignore_eos_reg && (s_token == eos_reg[TOKEN_BITS-1:0]);
                idx_reg <= '0;
            end
            if (state_reg != ST_IDLE) begin
                hit_reg <= hit_reg | cmp_hit;
            end
            if (state_reg == ST_WALK) begin
                idx_reg <= idx_reg + WALK_W'(1);
            end
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (deliver) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (deliver) begin
            m_reason_reg <= reason_next;
            m_count_reg  <= count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_finish_reason = m_reason_reg;
    assign m_tokens_seen   = m_count_reg;

    tssd_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tbl_wr  (tbl_wr),
        .walk    (walk),
        .history (history_reg),
        .fill    (fill_reg),
        .cmp_hit (cmp_hit)
    );

    // A token request always starts a table walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == CMD_TOKEN)) |=> (state_reg == ST_WALK))
        else $error("token request did not start a walk");

    // History fill never passes the history depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= LEN_W'(MAX_SEQ_LEN)))
        else $error("history fill out of range");

    // A stop hit found during the walk stays set through the walk and the last compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        (((state_reg == ST_WALK) || (state_reg == ST_LAST)) && hit_reg) |=> hit_reg)
        else $error("stop hit lost during walk");

    // A length finish needs at least one limit enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_finish_reason == FIN_LENGTH))
            |-> ((max_total_reg != '0) || (max_gen_reg != '0)))
        else $error("length finish with no limit set");

endmodule
